// ----- src/terrain_water_erosion_grid_macros.svh -----
// Assertion macros used by the checker of the water and erosion grid.
`ifndef TERRAIN_WATER_EROSION_GRID_MACROS_SVH
`define TERRAIN_WATER_EROSION_GRID_MACROS_SVH

// Same-cycle implication, sampled on the rising clock and quiet during reset.
`define TWE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("twe_chk: assertion failed");

// Next-cycle implication, sampled on the rising clock and quiet during reset.
`define TWE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("twe_chk: assertion failed");

`endif

// ----- src/twe_pkg.sv -----
// Types and constants of the water and erosion grid.
package twe_pkg;

    typedef enum logic [4:0] {
        S_IDLE, S_ISSUE, S_DRAIN, S_LOAD, S_MOIST0, S_MOIST1,
        S_F0, S_F1, S_F1D, S_F2, S_F3, S_F4, S_F5, S_F6, S_F6D, S_F7,
        S_P0, S_P1, S_P2, S_P3, S_WRN, S_WRC, S_MUL, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_MOIST = 2'd1,
        REQ_FLOW  = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    localparam logic [3:0] CFG_SURF_EVAP = 4'd0;
    localparam logic [3:0] CFG_GND_EVAP  = 4'd1;
    localparam logic [3:0] CFG_ABSORB    = 4'd2;
    localparam logic [3:0] CFG_RAIN      = 4'd3;
    localparam logic [3:0] CFG_FLOW      = 4'd4;
    localparam logic [3:0] CFG_PERMEATE  = 4'd5;
    localparam logic [3:0] CFG_ERO_RATE  = 4'd6;
    localparam logic [3:0] CFG_ERO_GAIN  = 4'd7;

    localparam logic [15:0] RST_SURF_EVAP = 16'd328;
    localparam logic [15:0] RST_GND_EVAP  = 16'd66;
    localparam logic [15:0] RST_ABSORB    = 16'd328;
    localparam logic [15:0] RST_RAIN      = 16'd786;
    localparam logic [15:0] RST_FLOW      = 16'd3277;
    localparam logic [15:0] RST_PERMEATE  = 16'd32768;
    localparam logic [15:0] RST_ERO_RATE  = 16'd655;
    localparam logic [15:0] RST_ERO_GAIN  = 16'd2560;

    localparam logic [3:0]  NB_FIRST  = 4'd0;
    localparam logic [3:0]  NB_CENTRE = 4'd4;
    localparam logic [3:0]  NB_LAST   = 4'd8;

    localparam logic [16:0] SQRT2_Q16 = 17'd92682;
    // ceil(2^28 / 10): exact quotient by ten for values below 2^26.
    localparam logic [24:0] RECIP10   = 25'd26843546;
    localparam logic [16:0] SAT_ONE   = 17'd65536;
    localparam logic [23:0] WATER_MAX = 24'hFFFFFF;
    localparam logic signed [23:0] HEIGHT_EDGE = 24'sd1044480;
    localparam logic signed [25:0] SLIDE_MIN   = 26'sd8192;
    localparam logic [21:0] ONE_Q12   = 22'd4096;

endpackage

// ----- src/terrain_water_erosion_grid.sv -----
// Water and erosion tile grid: request sequencer, tile memories and shared multiplier.
//
// Usage. Requests arrive on the input channel (i_in_valid / o_in_ready) and each one
// gives exactly one result beat on the output channel (o_out_valid / i_out_ready).
// Registers are written through the configuration channel, which is always ready,
// and must only be written while no request is in flight.
// Timing. One request is worked on at a time. Of all requests a flow step takes the
// longest from acceptance to the result beat. Its time is set by the single memory
// port, which reads the nine tiles one per cycle, and by the shared 48x16 multiplier,
// which forms each of up to ten products in turn, only as many as the step needs.
// The result waits in an output register, so a new request is accepted while an
// earlier result is still stalled by the receiver; the block then waits with the
// following result until the register is free.
// Reset clears the sequencer, the output valid and the registers to their defaults.
// Tile contents are not cleared: a tile must be loaded before it is stepped or read.
module terrain_water_erosion_grid #(
    parameter int GRID_W = 512,
    parameter int GRID_H = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic [8:0]         i_tile_x,
    input  logic [8:0]         i_tile_y,
    input  logic               i_rain,
    input  logic signed [23:0] i_load_height,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_status,
    output logic signed [23:0] o_tile_height,
    output logic [23:0]        o_tile_water,
    output logic [16:0]        o_tile_saturation,
    output logic [3:0]         o_neighbour_index,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int DEPTH = GRID_W * GRID_H;
    localparam int AW    = $clog2(DEPTH);

    // Row and column offsets of a neighbour code, row-major over a 3x3 window.
    function automatic logic [3:0] nb_offset(input logic [3:0] c);
        logic [3:0] v;
        unique case (c)
            4'd0:    v = {2'd0, 2'd0};
            4'd1:    v = {2'd0, 2'd1};
            4'd2:    v = {2'd0, 2'd2};
            4'd3:    v = {2'd1, 2'd0};
            4'd5:    v = {2'd1, 2'd2};
            4'd6:    v = {2'd2, 2'd0};
            4'd7:    v = {2'd2, 2'd1};
            4'd8:    v = {2'd2, 2'd2};
            default: v = {2'd1, 2'd1};
        endcase
        return v;
    endfunction

    function automatic logic signed [23:0] clamp_h(input logic signed [28:0] v);
        logic signed [23:0] r;
        if (v > 29'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -29'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic [16:0] clamp_s(input logic signed [29:0] v);
        logic [16:0] r;
        if (v < 30'sd0) begin
            r = '0;
        end else if (v > $signed({13'd0, twe_pkg::SAT_ONE})) begin
            r = twe_pkg::SAT_ONE;
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

    function automatic logic [23:0] clamp_w(input logic [24:0] v);
        return v[24] ? twe_pkg::WATER_MAX : v[23:0];
    endfunction

    logic signed [23:0] height_mem [DEPTH];
    logic [23:0]        water_mem  [DEPTH];
    logic [16:0]        soak_mem   [DEPTH];

    twe_pkg::t_state r_state, n_state, r_ret;
    twe_pkg::t_req   r_req;

    logic [15:0] r_cfg_sev, r_cfg_gev, r_cfg_abs, r_cfg_rain;
    logic [15:0] r_cfg_flow, r_cfg_perm, r_cfg_erate, r_cfg_egain;

    logic [8:0]         r_x, r_y;
    logic               r_rain, r_bad;
    logic signed [23:0] r_lh;
    logic [3:0]         r_cnt, r_didx, r_idx;
    logic               r_dv, r_found, r_mstep;
    logic signed [23:0] r_rd_h, r_h, r_hn;
    logic [23:0]        r_rd_w, r_w, r_wn;
    logic [16:0]        r_rd_s, r_s, r_sn;
    logic signed [25:0] r_best, r_td;
    logic [24:0]        r_tdabs;
    logic               r_tdneg, r_neg, r_f2neg;
    logic [43:0]        r_mv;
    logic [28:0]        r_mw;
    logic [30:0]        r_ef;
    logic signed [27:0] r_er;
    logic [21:0]        r_f2abs;
    logic [47:0]        r_ma;
    logic [31:0]        r_mb;
    logic [79:0]        r_acc;

    logic               r_ovalid, r_ostat;
    logic signed [23:0] r_oh;
    logic [23:0]        r_ow;
    logic [16:0]        r_os;
    logic [3:0]         r_oidx;

    logic               in_fire, in_bad, mem_we, mem_re, out_free;
    logic [3:0]         a_sel, a_off;
    logic [9:0]         a_row, a_col;
    logic [AW-1:0]      a_addr;
    logic signed [23:0] wr_h, load_h;
    logic [23:0]        wr_w;
    logic [16:0]        wr_s;

    // Input admission and range check.
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_ovalid || i_out_ready;

    always_comb begin
        if (i_req_type == twe_pkg::REQ_MOIST || i_req_type == twe_pkg::REQ_FLOW) begin
            in_bad = !((32'(i_tile_x) >= 32'd2) && (32'(i_tile_x) <= 32'(GRID_W - 2)) &&
                       (32'(i_tile_y) >= 32'd2) && (32'(i_tile_y) <= 32'(GRID_H - 2)));
        end else begin
            in_bad = !((32'(i_tile_x) < 32'(GRID_W)) && (32'(i_tile_y) < 32'(GRID_H)));
        end
    end

    // Tile address of the selected window position.
    assign a_off  = nb_offset(a_sel);
    assign a_row  = 10'(r_y) + 10'(a_off[3:2]) - 10'd1;
    assign a_col  = 10'(r_x) + 10'(a_off[1:0]) - 10'd1;
    assign a_addr = AW'(32'(a_row) * 32'(GRID_W) + 32'(a_col));
    assign load_h = (r_x == '0 || r_y == '0) ? twe_pkg::HEIGHT_EDGE : r_lh;

    // Levels, drop and flags of the flow step.
    logic signed [25:0] lv_c, lv_n, lv_d, td;
    logic signed [24:0] h_ext, h_mag, th;
    logic               f_move, f_diag, f_slide, f_perm;
    logic [3:0]         idx_off;

    assign lv_c   = {{2{r_h[23]}}, r_h} + $signed({2'b0, r_w});
    assign lv_n   = {{2{r_hn[23]}}, r_hn} + $signed({2'b0, r_wn});
    assign lv_d   = {{2{r_rd_h[23]}}, r_rd_h} + $signed({2'b0, r_rd_w});
    assign h_ext  = {r_h[23], r_h};
    assign h_mag  = -h_ext;
    assign th     = r_h[23] ? -(h_mag & ~25'sd4095) : (h_ext & ~25'sd4095);
    assign td     = {th[24], th} - {{2{r_hn[23]}}, r_hn};
    assign f_move = (r_w != '0) && (lv_n < lv_c);
    assign idx_off = nb_offset(r_idx);
    assign f_diag = (idx_off[3:2] != 2'd1) && (idx_off[1:0] != 2'd1);
    assign f_slide = r_td > twe_pkg::SLIDE_MIN;
    assign f_perm = r_s > r_sn;

    // Moisture arithmetic.
    logic [28:0] m_w16, m_w1;
    logic [16:0] m_s1;
    logic [29:0] m_s2;
    logic [28:0] m_w2;

    always_comb begin
        m_w16 = {1'b0, r_w, 4'b0} + (r_rain ? 29'(r_cfg_rain) : 29'd0);
        m_w1  = m_w16;
        m_s1  = r_s;
        if (m_w16 != '0) begin
            m_w1 = (m_w16 >= 29'(r_cfg_sev)) ? m_w16 - 29'(r_cfg_sev) : '0;
        end else begin
            m_s1 = (r_s >= 17'(r_cfg_gev)) ? r_s - 17'(r_cfg_gev) : '0;
        end
        m_s2 = 30'(r_s);
        m_w2 = r_mw;
        if (r_s < twe_pkg::SAT_ONE) begin
            if (r_mw < 29'(r_cfg_abs)) begin
                m_s2 = 30'(r_s) + 30'(r_mw);
                m_w2 = '0;
            end else begin
                m_s2 = 30'(r_s) + 30'(r_cfg_abs);
                m_w2 = r_mw - 29'(r_cfg_abs);
            end
        end
    end

    // Flow arithmetic on the products of the shared multiplier.
    logic [23:0]        f_moved;
    logic               f_part;
    logic [30:0]        f_ef;
    logic signed [31:0] f_d;
    logic [31:0]        f_dabs;
    logic signed [48:0] f_g, f_gsh;
    logic signed [41:0] f_fac, f_fabs;
    logic               f_ovf;
    logic [26:0]        f_erfl, f_ercl;
    logic signed [27:0] f_er;
    logic [21:0]        f_q;
    logic [26:0]        f_pfl, f_pcl;
    logic signed [29:0] f_p;
    logic [63:0]        mul_p;

    assign f_part  = r_mv < {4'b0, r_w, 16'b0};
    assign f_moved = f_part ? r_mv[39:16] : r_w;
    assign f_ef    = r_acc[58:28];
    assign f_d     = $signed({1'b0, f_ef}) - $signed({16'b0, r_cfg_rain});
    assign f_dabs  = f_d[31] ? 32'(-f_d) : 32'(f_d);
    assign f_g     = r_neg ? -$signed({1'b0, r_acc[47:0]}) : $signed({1'b0, r_acc[47:0]});
    assign f_gsh   = f_g >>> 8;
    assign f_fac   = f_gsh[41:0] + 42'sd65536;
    assign f_fabs  = f_fac[41] ? -f_fac : f_fac;
    // The force saturates once the product passes 2^46.
    assign f_ovf   = (|r_acc[79:47]) || (r_acc[46] && (|r_acc[45:0]));
    assign f_erfl  = r_acc[46:20];
    assign f_ercl  = r_acc[46:20] + 27'(|r_acc[19:0]);
    always_comb begin
        if (f_ovf) begin
            f_er = r_neg ? -28'sd67108864 : 28'sd67108864;
        end else begin
            f_er = r_neg ? -$signed({1'b0, f_ercl}) : $signed({1'b0, f_erfl});
        end
    end
    assign f_q   = r_acc[49:28];
    assign f_pfl = r_acc[54:28];
    assign f_pcl = r_acc[54:28] + 27'(|r_acc[27:0]);
    assign f_p   = r_f2neg ? -$signed({3'b0, f_pcl}) : $signed({3'b0, f_pfl});
    assign mul_p = r_ma * (r_mstep ? r_mb[15:0] : r_mb[31:16]);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            twe_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (in_bad) begin
                        n_state = twe_pkg::S_DONE;
                    end else if (i_req_type == twe_pkg::REQ_LOAD) begin
                        n_state = twe_pkg::S_LOAD;
                    end else begin
                        n_state = twe_pkg::S_ISSUE;
                    end
                end
            end
            twe_pkg::S_ISSUE: begin
                if (r_cnt == twe_pkg::NB_LAST || r_req != twe_pkg::REQ_FLOW) begin
                    n_state = twe_pkg::S_DRAIN;
                end
            end
            twe_pkg::S_DRAIN: begin
                unique case (r_req)
                    twe_pkg::REQ_MOIST: n_state = twe_pkg::S_MOIST0;
                    twe_pkg::REQ_FLOW:  n_state = twe_pkg::S_F0;
                    default:            n_state = twe_pkg::S_DONE;
                endcase
            end
            twe_pkg::S_LOAD:   n_state = twe_pkg::S_DONE;
            twe_pkg::S_MOIST0: n_state = twe_pkg::S_MOIST1;
            twe_pkg::S_MOIST1: n_state = twe_pkg::S_WRC;
            twe_pkg::S_F0:     n_state = f_move ? twe_pkg::S_MUL : twe_pkg::S_P0;
            twe_pkg::S_F1:     n_state = f_diag ? twe_pkg::S_MUL : twe_pkg::S_F2;
            twe_pkg::S_F1D:    n_state = twe_pkg::S_F2;
            twe_pkg::S_F2:     n_state = twe_pkg::S_MUL;
            twe_pkg::S_F3:     n_state = twe_pkg::S_MUL;
            twe_pkg::S_F4:     n_state = twe_pkg::S_MUL;
            twe_pkg::S_F5:     n_state = f_slide ? twe_pkg::S_MUL : twe_pkg::S_F7;
            twe_pkg::S_F6:     n_state = f_diag ? twe_pkg::S_MUL : twe_pkg::S_F7;
            twe_pkg::S_F6D:    n_state = twe_pkg::S_F7;
            twe_pkg::S_F7:     n_state = twe_pkg::S_P0;
            twe_pkg::S_P0:     n_state = f_perm ? twe_pkg::S_MUL : twe_pkg::S_WRN;
            twe_pkg::S_P1:     n_state = twe_pkg::S_MUL;
            twe_pkg::S_P2:     n_state = twe_pkg::S_MUL;
            twe_pkg::S_P3:     n_state = twe_pkg::S_WRN;
            twe_pkg::S_WRN:    n_state = twe_pkg::S_WRC;
            twe_pkg::S_WRC:    n_state = twe_pkg::S_DONE;
            twe_pkg::S_MUL:    n_state = r_mstep ? r_ret : twe_pkg::S_MUL;
            twe_pkg::S_DONE:   n_state = out_free ? twe_pkg::S_IDLE : twe_pkg::S_DONE;
            default:           n_state = twe_pkg::S_IDLE;
        endcase
    end

    // Memory port and handshake outputs.
    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        a_sel  = twe_pkg::NB_CENTRE;
        wr_h   = r_h;
        wr_w   = r_w;
        wr_s   = r_s;
        unique case (r_state)
            twe_pkg::S_ISSUE: begin
                mem_re = 1'b1;
                a_sel  = r_cnt;
            end
            twe_pkg::S_LOAD: begin
                mem_we = 1'b1;
                wr_h   = load_h;
                wr_w   = '0;
                wr_s   = '0;
            end
            twe_pkg::S_WRN: begin
                mem_we = 1'b1;
                a_sel  = r_idx;
                wr_h   = r_hn;
                wr_w   = r_wn;
                wr_s   = r_sn;
            end
            twe_pkg::S_WRC: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign o_in_ready  = (r_state == twe_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            height_mem[a_addr] <= wr_h;
            water_mem[a_addr]  <= wr_w;
            soak_mem[a_addr]   <= wr_s;
        end
        if (mem_re) begin
            r_rd_h <= height_mem[a_addr];
            r_rd_w <= water_mem[a_addr];
            r_rd_s <= soak_mem[a_addr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= twe_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_dv     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= mem_re;
            if (r_state == twe_pkg::S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sev   <= twe_pkg::RST_SURF_EVAP;
            r_cfg_gev   <= twe_pkg::RST_GND_EVAP;
            r_cfg_abs   <= twe_pkg::RST_ABSORB;
            r_cfg_rain  <= twe_pkg::RST_RAIN;
            r_cfg_flow  <= twe_pkg::RST_FLOW;
            r_cfg_perm  <= twe_pkg::RST_PERMEATE;
            r_cfg_erate <= twe_pkg::RST_ERO_RATE;
            r_cfg_egain <= twe_pkg::RST_ERO_GAIN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                twe_pkg::CFG_SURF_EVAP: r_cfg_sev   <= i_cfg_data;
                twe_pkg::CFG_GND_EVAP:  r_cfg_gev   <= i_cfg_data;
                twe_pkg::CFG_ABSORB:    r_cfg_abs   <= i_cfg_data;
                twe_pkg::CFG_RAIN:      r_cfg_rain  <= i_cfg_data;
                twe_pkg::CFG_FLOW:      r_cfg_flow  <= i_cfg_data;
                twe_pkg::CFG_PERMEATE:  r_cfg_perm  <= i_cfg_data;
                twe_pkg::CFG_ERO_RATE:  r_cfg_erate <= i_cfg_data;
                twe_pkg::CFG_ERO_GAIN:  r_cfg_egain <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r_didx <= r_cnt;
        // Tile data read in the previous cycle: the centre is kept, the others
        // compete for the lowest level, the first strictly lowest one winning.
        if (r_dv) begin
            if (r_didx == twe_pkg::NB_CENTRE) begin
                r_h <= r_rd_h;
                r_w <= r_rd_w;
                r_s <= r_rd_s;
            end else if (!r_found || lv_d < r_best) begin
                r_found <= 1'b1;
                r_best  <= lv_d;
                r_idx   <= r_didx;
                r_hn    <= r_rd_h;
                r_wn    <= r_rd_w;
                r_sn    <= r_rd_s;
            end
        end

        unique case (r_state)
            twe_pkg::S_IDLE: begin
                if (in_fire) begin
                    r_req   <= twe_pkg::t_req'(i_req_type);
                    r_x     <= i_tile_x;
                    r_y     <= i_tile_y;
                    r_rain  <= i_rain;
                    r_lh    <= i_load_height;
                    r_bad   <= in_bad;
                    r_found <= 1'b0;
                    r_idx   <= twe_pkg::NB_CENTRE;
                    r_cnt   <= (i_req_type == twe_pkg::REQ_FLOW) ? twe_pkg::NB_FIRST
                                                                 : twe_pkg::NB_CENTRE;
                end
            end
            twe_pkg::S_ISSUE: begin
                r_cnt <= r_cnt + 4'd1;
            end
            twe_pkg::S_LOAD: begin
                r_h <= load_h;
                r_w <= '0;
                r_s <= '0;
            end
            twe_pkg::S_MOIST0: begin
                r_mw <= m_w1;
                r_s  <= m_s1;
            end
            twe_pkg::S_MOIST1: begin
                r_s <= clamp_s($signed(m_s2));
                r_w <= clamp_w(m_w2[28:4]);
            end
            twe_pkg::S_F0: begin
                r_td    <= td;
                r_tdneg <= td[25];
                r_tdabs <= td[25] ? 25'(-td) : 25'(td);
                r_ma    <= 48'(lv_c - lv_n);
                r_mb    <= 32'(r_cfg_flow);
                r_ret   <= twe_pkg::S_F1;
                r_mstep <= 1'b0;
            end
            twe_pkg::S_F1: begin
                r_mv    <= r_acc[43:0];
                r_ma    <= r_acc[47:0];
                r_mb    <= 32'(twe_pkg::SQRT2_Q16);
                r_ret   <= twe_pkg::S_F1D;
                r_mstep <= 1'b0;
            end
            twe_pkg::S_F1D: begin
                r_mv <= r_acc[59:16];
            end
            twe_pkg::S_F2: begin
                r_wn    <= clamp_w(25'(r_wn) + 25'(f_moved));
                r_w     <= r_w - f_moved;
                r_ma    <= 48'(r_mv);
                r_mb    <= 32'(r_cfg_erate);
                r_ret   <= twe_pkg::S_F3;
                r_mstep <= 1'b0;
            end
            twe_pkg::S_F3: begin
                r_ef    <= f_ef;
                r_neg   <= f_d[31];
                r_ma    <= 48'(f_dabs);
                r_mb    <= 32'(r_cfg_egain);
                r_ret   <= twe_pkg::S_F4;
                r_mstep <= 1'b0;
            end
            twe_pkg::S_F4: begin
                r_neg   <= f_fac[41];
                r_ma    <= 48'(f_fabs);
                r_mb    <= 32'(r_ef);
                r_ret   <= twe_pkg::S_F5;
                r_mstep <= 1'b0;
            end
            twe_pkg::S_F5: begin
                r_er    <= f_er;
                r_ma    <= 48'(r_tdabs);
                r_mb    <= 32'(twe_pkg::RECIP10);
                r_ret   <= twe_pkg::S_F6;
                r_mstep <= 1'b0;
            end
            twe_pkg::S_F6: begin
                r_er    <= $signed({6'b0, f_q});
                r_ma    <= 48'(f_q);
                r_mb    <= 32'(twe_pkg::SQRT2_Q16);
                r_ret   <= twe_pkg::S_F6D;
                r_mstep <= 1'b0;
            end
            twe_pkg::S_F6D: begin
                r_er <= $signed({1'b0, r_acc[42:16]});
            end
            twe_pkg::S_F7: begin
                r_hn <= clamp_h({{5{r_hn[23]}}, r_hn} + {r_er[27], r_er});
                r_h  <= clamp_h({{5{r_h[23]}}, r_h} - {r_er[27], r_er});
            end
            twe_pkg::S_P0: begin
                r_ma    <= 48'(r_tdabs);
                r_mb    <= 32'(twe_pkg::RECIP10);
                r_ret   <= twe_pkg::S_P1;
                r_mstep <= 1'b0;
            end
            twe_pkg::S_P1: begin
                // Permeation factor is one plus the signed drop over ten.
                if (!r_tdneg) begin
                    r_f2abs <= twe_pkg::ONE_Q12 + f_q;
                    r_f2neg <= 1'b0;
                end else if (f_q > twe_pkg::ONE_Q12) begin
                    r_f2abs <= f_q - twe_pkg::ONE_Q12;
                    r_f2neg <= 1'b1;
                end else begin
                    r_f2abs <= twe_pkg::ONE_Q12 - f_q;
                    r_f2neg <= 1'b0;
                end
                r_ma    <= 48'(r_s - r_sn);
                r_mb    <= 32'(r_cfg_perm);
                r_ret   <= twe_pkg::S_P2;
                r_mstep <= 1'b0;
            end
            twe_pkg::S_P2: begin
                r_ma    <= r_acc[47:0];
                r_mb    <= 32'(r_f2abs);
                r_ret   <= twe_pkg::S_P3;
                r_mstep <= 1'b0;
            end
            twe_pkg::S_P3: begin
                r_sn <= clamp_s($signed({13'd0, r_sn}) + f_p);
                r_s  <= clamp_s($signed({13'd0, r_s}) - f_p);
            end
            twe_pkg::S_MUL: begin
                r_mstep <= 1'b1;
                if (r_mstep) begin
                    r_acc <= {r_acc[63:0], 16'b0} + 80'(mul_p);
                end else begin
                    r_acc <= 80'(mul_p);
                end
            end
            twe_pkg::S_DONE: begin
                if (out_free) begin
                    r_ostat <= r_bad;
                    r_oh    <= r_bad ? '0 : r_h;
                    r_ow    <= r_bad ? '0 : r_w;
                    r_os    <= r_bad ? '0 : r_s;
                    r_oidx  <= r_bad ? twe_pkg::NB_CENTRE : r_idx;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid       = r_ovalid;
    assign o_status          = r_ostat;
    assign o_tile_height     = r_oh;
    assign o_tile_water      = r_ow;
    assign o_tile_saturation = r_os;
    assign o_neighbour_index = r_oidx;

endmodule

// ----- src/twe_chk.sv -----
// Port checker of the water and erosion grid, bound to the top level.
`include "terrain_water_erosion_grid_macros.svh"

module twe_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [1:0]         i_req_type,
    input logic [8:0]         i_tile_x,
    input logic [8:0]         i_tile_y,
    input logic               i_rain,
    input logic signed [23:0] i_load_height,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_status,
    input logic signed [23:0] o_tile_height,
    input logic [23:0]        o_tile_water,
    input logic [16:0]        o_tile_saturation,
    input logic [3:0]         o_neighbour_index,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [3:0]         i_cfg_index,
    input logic [15:0]        i_cfg_data
);

    // A stalled result beat stays offered with the same height.
    `TWE_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_tile_height))
    // A rejected coordinate reports an empty tile and no neighbour.
    `TWE_ASSERT_IMP(a_err_zero, o_out_valid && o_status, o_tile_height == 0 && o_tile_water == 0 && o_tile_saturation == 0 && o_neighbour_index == twe_pkg::NB_CENTRE)
    `TWE_ASSERT_IMP(a_sat_range, o_out_valid, o_tile_saturation <= twe_pkg::SAT_ONE)
    `TWE_ASSERT_IMP(a_nb_range, o_out_valid, o_neighbour_index <= twe_pkg::NB_LAST)
    // Every accepted request leaves the block busy in the cycle after acceptance.
    `TWE_ASSERT_NXT(a_busy, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind terrain_water_erosion_grid twe_chk u_twe_chk (.*);
